### rtl/core/kars_pkg.sv
// Shared types, codes and constants for the key auto-repeat slot bank.
package kars_pkg;

  // Default bank size and result cap for one tick
  localparam int SLOT_COUNT_DEF = 10;
  localparam int MAX_RESULTS    = 10;
  localparam int NW             = $clog2(MAX_RESULTS + 1);

  // Field widths
  localparam int POS_W   = 8;
  localparam int LAYER_W = 5;
  localparam int WORD_W  = 32;
  localparam int CNT_W   = 16;
  localparam int FUNC_W  = 2;
  localparam int CIDX_W  = 2;

  // Input function codes
  localparam logic [FUNC_W-1:0] FUNC_PRESS   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd2;

  // Register indexes
  localparam logic [CIDX_W-1:0] CFG_INITIAL_DELAY  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_REPEAT_DELAY   = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_PRESS_DURATION = 2'd2;

  // Register reset values
  localparam logic [CNT_W-1:0] INITIAL_DELAY_RST  = 16'd500;
  localparam logic [CNT_W-1:0] REPEAT_DELAY_RST   = 16'd100;
  localparam logic [CNT_W-1:0] PRESS_DURATION_RST = 16'd20;

  // Queue depth between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_TICK    = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_RELEASE = 2'd1,
    EV_NO_SLOT = 2'd2
  } ev_t;

  typedef enum logic [1:0] {
    PH_FREE = 2'd0,
    PH_INIT = 2'd1,
    PH_REP  = 2'd2,
    PH_REL  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FREE,
    ST_TAKE,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    kind_t               kind;
    logic [POS_W-1:0]    pos;
    logic [LAYER_W-1:0]  layer;
    logic [WORD_W-1:0]   word_a;
    logic [WORD_W-1:0]   word_b;
  } item_t;

  typedef struct packed {
    ev_t                 kind;
    logic [POS_W-1:0]    pos;
    logic [LAYER_W-1:0]  layer;
    logic [WORD_W-1:0]   word_a;
    logic [WORD_W-1:0]   word_b;
  } result_t;

  typedef struct packed {
    logic [CNT_W-1:0] initial_delay;
    logic [CNT_W-1:0] repeat_delay;
    logic [CNT_W-1:0] press_duration;
  } cfg_t;

endpackage

### rtl/core/key_auto_repeat_slots.sv
// Top level of the key auto-repeat slot bank.
//
//  channel | ports                          | beat taken when
//  --------+--------------------------------+---------------------------
//  input   | in_valid/in_ready, in_*        | in_valid && in_ready
//  result  | out_valid/out_ready, out_*     | out_valid && out_ready
//  config  | cfg_we, cfg_index, cfg_data    | cfg_we
//
// Each beat passes through the back end as one pass of the scan over the slot
// bank, one slot a cycle unless the result channel stalls, plus free, take and
// flush steps. A two-entry queue lets the front accept beats during the scan.
// Reset (synchronous, active low) frees every slot and loads default delays.
// A stalled result channel holds the scan at the next slot that must emit.
module key_auto_repeat_slots import kars_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [POS_W-1:0]    in_key_position,
  input  logic [LAYER_W-1:0]  in_key_layer,
  input  logic [WORD_W-1:0]   in_bind_word_a,
  input  logic [WORD_W-1:0]   in_bind_word_b,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_event_kind,
  output logic [POS_W-1:0]    out_position,
  output logic [LAYER_W-1:0]  out_layer,
  output logic [WORD_W-1:0]   out_word_a,
  output logic [WORD_W-1:0]   out_word_b,
  output logic                out_last_of_run,
  input  logic                cfg_we,
  input  logic [CIDX_W-1:0]   cfg_index,
  input  logic [CNT_W-1:0]    cfg_data
);

  cfg_t     cfg_r;
  logic     q_valid, q_pop;
  item_t    q_item;
  result_t  res;

  // Configuration registers; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.initial_delay  <= INITIAL_DELAY_RST;
      cfg_r.repeat_delay   <= REPEAT_DELAY_RST;
      cfg_r.press_duration <= PRESS_DURATION_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INITIAL_DELAY:  cfg_r.initial_delay  <= cfg_data;
        CFG_REPEAT_DELAY:   cfg_r.repeat_delay   <= cfg_data;
        CFG_PRESS_DURATION: cfg_r.press_duration <= cfg_data;
        default: ;
      endcase
    end
  end

  kars_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_key_position (in_key_position),
    .in_key_layer    (in_key_layer),
    .in_bind_word_a  (in_bind_word_a),
    .in_bind_word_b  (in_bind_word_b),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  kars_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res),
    .out_last  (out_last_of_run)
  );

  assign out_event_kind = res.kind;
  assign out_position   = res.pos;
  assign out_layer      = res.layer;
  assign out_word_a     = res.word_a;
  assign out_word_b     = res.word_b;

endmodule

### rtl/core/kars_front.sv
// Front end: accepts input beats, classifies them and queues them for the back end.
module kars_front import kars_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [POS_W-1:0]    in_key_position,
  input  logic [LAYER_W-1:0]  in_key_layer,
  input  logic [WORD_W-1:0]   in_bind_word_a,
  input  logic [WORD_W-1:0]   in_bind_word_b,
  output logic                q_valid,
  output item_t               q_item,
  input  logic                q_pop
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  item_t              mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_QW-1:0]  count_r;
  item_t              item;
  logic               known;
  logic               push;

  // Classify the beat; unknown codes are dropped here
  always_comb begin
    item.pos    = in_key_position;
    item.layer  = in_key_layer;
    item.word_a = in_bind_word_a;
    item.word_b = in_bind_word_b;
    known       = 1'b1;
    unique case (in_func)
      FUNC_PRESS:   item.kind = KIND_PRESS;
      FUNC_RELEASE: item.kind = KIND_RELEASE;
      FUNC_TICK:    item.kind = KIND_TICK;
      default: begin
        item.kind = KIND_TICK;
        known     = 1'b0;
      end
    endcase
  end

  assign in_ready = (count_r != CNT_QW'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready && known;
  assign q_valid  = (count_r != '0);
  assign q_item   = mem_r[rd_ptr_r];

  // Store queued beats
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CNT_QW'(push) - CNT_QW'(q_pop);
    end
  end

endmodule

### rtl/core/kars_back.sv
// Back end: slot bank, scan sequencer and output register.
module kars_back import kars_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                q_valid,
  input  item_t               q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output result_t             out_res,
  output logic                out_last
);

  localparam int IDXW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Slot bank
  phase_t              phase_r [SLOT_COUNT];
  logic [CNT_W-1:0]    cd_r    [SLOT_COUNT];
  logic [POS_W-1:0]    pos_r   [SLOT_COUNT];
  logic [LAYER_W-1:0]  layer_r [SLOT_COUNT];
  logic [WORD_W-1:0]   wa_r    [SLOT_COUNT];
  logic [WORD_W-1:0]   wb_r    [SLOT_COUNT];

  state_t            state_r, state_nxt;
  item_t             item_r;
  logic [IDXW-1:0]   idx_r, idx_nxt;
  logic              hit_v_r, hit_v_nxt, free_v_r, free_v_nxt;
  logic [IDXW-1:0]   hit_idx_r, hit_idx_nxt, free_idx_r, free_idx_nxt;
  logic [NW-1:0]     n_r;

  result_t           pend_r, out_r;
  logic              pend_v_r, out_v_r, out_last_r;

  // Slot read at the scan index
  phase_t            rd_ph;
  logic [CNT_W-1:0]  rd_cd;
  result_t           rd_res;
  logic              last_idx, hit_now, free_now, held;

  // Slot write controls
  logic              ph_we, cd_we, key_we;
  phase_t            ph_wd;
  logic [CNT_W-1:0]  cd_wd;

  // Emission controls
  logic              can_push, emit_ok, emit, flush, stall;
  result_t           emit_res;
  logic [CNT_W-1:0]  gap_init, gap_rep;

  assign rd_ph         = phase_r[idx_r];
  assign rd_cd         = cd_r[idx_r];
  assign rd_res.kind   = EV_PRESS;
  assign rd_res.pos    = pos_r[idx_r];
  assign rd_res.layer  = layer_r[idx_r];
  assign rd_res.word_a = wa_r[idx_r];
  assign rd_res.word_b = wb_r[idx_r];

  assign last_idx = (idx_r == IDXW'(SLOT_COUNT - 1));
  assign held     = (rd_ph == PH_INIT) || (rd_ph == PH_REP);
  assign hit_now  = (rd_ph != PH_FREE) && (pos_r[idx_r] == item_r.pos);
  assign free_now = (rd_ph == PH_FREE) || hit_now;

  assign can_push = !out_v_r || out_ready;
  assign emit_ok  = !pend_v_r || can_push;

  // Gap after a press, floored at zero
  assign gap_init = (cfg.initial_delay > cfg.press_duration) ?
                    cfg.initial_delay - cfg.press_duration : '0;
  assign gap_rep  = (cfg.repeat_delay > cfg.press_duration) ?
                    cfg.repeat_delay - cfg.press_duration : '0;

  // Scan bookkeeping for press and release lookups
  always_comb begin
    hit_v_nxt    = hit_v_r;
    hit_idx_nxt  = hit_idx_r;
    free_v_nxt   = free_v_r;
    free_idx_nxt = free_idx_r;
    if (state_r == ST_SCAN && item_r.kind != KIND_TICK) begin
      if (hit_now) begin
        hit_v_nxt   = 1'b1;
        hit_idx_nxt = idx_r;
      end
      if (free_now && !free_v_r && item_r.kind == KIND_PRESS) begin
        free_v_nxt   = 1'b1;
        free_idx_nxt = idx_r;
      end
    end
  end

  // Datapath actions per state
  always_comb begin
    ph_we    = 1'b0;
    cd_we    = 1'b0;
    key_we   = 1'b0;
    ph_wd    = PH_FREE;
    cd_wd    = '0;
    emit     = 1'b0;
    emit_res = rd_res;
    flush    = 1'b0;
    stall    = 1'b0;
    q_pop    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        q_pop = q_valid;
      end
      ST_SCAN: begin
        if (item_r.kind == KIND_TICK && rd_ph != PH_FREE) begin
          if (rd_cd > CNT_W'(1)) begin
            cd_we = 1'b1;
            cd_wd = rd_cd - 1'b1;
          end else if (n_r >= NW'(MAX_RESULTS)) begin
            cd_we = 1'b1;
            cd_wd = '0;
          end else if (!emit_ok) begin
            stall = 1'b1;
          end else begin
            emit  = 1'b1;
            cd_we = 1'b1;
            ph_we = 1'b1;
            if (held) begin
              emit_res.kind = EV_RELEASE;
              cd_wd         = (rd_ph == PH_INIT) ? gap_init : gap_rep;
              ph_wd         = PH_REL;
            end else begin
              emit_res.kind = EV_PRESS;
              cd_wd         = cfg.press_duration;
              ph_wd         = PH_REP;
            end
          end
        end
      end
      ST_FREE: begin
        if (held && !emit_ok) begin
          stall = 1'b1;
        end else begin
          emit          = held;
          emit_res.kind = EV_RELEASE;
          ph_we         = 1'b1;
          ph_wd         = PH_FREE;
          cd_we         = 1'b1;
          cd_wd         = '0;
        end
      end
      ST_TAKE: begin
        emit_res.kind   = free_v_r ? EV_PRESS : EV_NO_SLOT;
        emit_res.pos    = item_r.pos;
        emit_res.layer  = item_r.layer;
        emit_res.word_a = item_r.word_a;
        emit_res.word_b = item_r.word_b;
        if (!emit_ok) begin
          stall = 1'b1;
        end else begin
          emit   = 1'b1;
          key_we = free_v_r;
          ph_we  = free_v_r;
          ph_wd  = PH_INIT;
          cd_we  = free_v_r;
          cd_wd  = cfg.press_duration;
        end
      end
      ST_FLUSH: begin
        if (pend_v_r && !can_push) begin
          stall = 1'b1;
        end else begin
          flush = pend_v_r;
        end
      end
      default: begin
        stall = 1'b1;
      end
    endcase
  end

  // Next state and scan index
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        if (q_valid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          if (!last_idx) begin
            idx_nxt = idx_r + 1'b1;
          end else if (item_r.kind == KIND_TICK) begin
            state_nxt = ST_FLUSH;
          end else if (hit_v_nxt) begin
            state_nxt = ST_FREE;
            idx_nxt   = hit_idx_nxt;
          end else if (item_r.kind == KIND_PRESS) begin
            state_nxt = ST_TAKE;
            idx_nxt   = free_idx_nxt;
          end else begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FREE: begin
        if (!stall) begin
          if (item_r.kind == KIND_PRESS) begin
            state_nxt = ST_TAKE;
            idx_nxt   = free_idx_r;
          end else begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_TAKE: begin
        if (!stall) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      idx_r    <= '0;
      hit_v_r  <= 1'b0;
      free_v_r <= 1'b0;
      n_r      <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      if (q_pop) begin
        hit_v_r  <= 1'b0;
        free_v_r <= 1'b0;
        n_r      <= '0;
      end else begin
        hit_v_r  <= hit_v_nxt;
        free_v_r <= free_v_nxt;
        if (emit) begin
          n_r <= n_r + 1'b1;
        end
      end
    end
  end

  // Hold the current beat and lookup indexes
  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_item;
    end
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
  end

  // Slot phase and countdown
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        phase_r[i] <= PH_FREE;
        cd_r[i]    <= '0;
      end
    end else begin
      if (ph_we) begin
        phase_r[idx_r] <= ph_wd;
      end
      if (cd_we) begin
        cd_r[idx_r] <= cd_wd;
      end
    end
  end

  // Slot key data
  always_ff @(posedge clk) begin
    if (key_we) begin
      pos_r[idx_r]   <= item_r.pos;
      layer_r[idx_r] <= item_r.layer;
      wa_r[idx_r]    <= item_r.word_a;
      wb_r[idx_r]    <= item_r.word_b;
    end
  end

  // Hold one result back so the final one can be marked
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
      out_last_r <= 1'b0;
    end else begin
      if (out_v_r && out_ready) begin
        out_v_r <= 1'b0;
      end
      if (emit) begin
        pend_r   <= emit_res;
        pend_v_r <= 1'b1;
        if (pend_v_r) begin
          out_r      <= pend_r;
          out_v_r    <= 1'b1;
          out_last_r <= 1'b0;
        end
      end else if (flush) begin
        pend_v_r   <= 1'b0;
        out_r      <= pend_r;
        out_v_r    <= 1'b1;
        out_last_r <= 1'b1;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_res   = out_r;
  assign out_last  = out_last_r;

endmodule
